FILE: rtl/cma_pkg.sv
// Shared types, constants and helper functions for the centered moving average.
`default_nettype none

package cma_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int STORE_DEPTH  = MAX_WINDOW + 1;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int WIN_W        = 7;
  localparam int SPAN_W       = WIN_W - 1;
  localparam int SUM_W        = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int DIV_BITS     = 4;
  localparam int DIV_STEPS    = (SUM_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W        = DIV_STEPS * DIV_BITS;
  localparam int CNT_W        = $clog2(DIV_STEPS);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [WIN_W-1:0]  win_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_EMIT,
    ST_FL_RD,
    ST_FL_EM
  } cma_state_t;

  function automatic win_t win_clamp(input win_t w);
    win_t r;
    r = w;
    if (w == '0) begin
      r = win_t'(1);
    end else if (w > win_t'(MAX_WINDOW)) begin
      r = win_t'(MAX_WINDOW);
    end
    return r;
  endfunction

  function automatic addr_t slot_back(input addr_t cur, input win_t back);
    logic [ADDR_W:0] t;
    t = {1'b0, cur} + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(back);
    if (t >= (ADDR_W+1)'(STORE_DEPTH)) begin
      t = t - (ADDR_W+1)'(STORE_DEPTH);
    end
    return t[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/centered_moving_average.sv
// Centered moving average over sample sequences, with a circular sample store.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_stall   in_sample, in_last_in
//   out_      output     out_valid/out_stall out_value, out_last_out
//   cfg_      input      cfg_valid/cfg_ready cfg_window_length
//
// A sample with no result goes from the calculation state back to idle, a raw result goes on to the emit state,
// and a mean goes through the divide state first, set by the 4-bit-per-cycle divider by the window length.
// On the last sample, each remaining flushed position is read from the store in ST_FL_RD, then emitted in ST_FL_EM.
// Reset is synchronous and active low; the store needs no clearing pass.
// The output register lets a new sample be accepted while a result waits under out_stall.
`default_nettype none

module centered_moving_average (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cma_pkg::SAMPLE_WIDTH-1:0] in_sample,
  input  logic                               in_last_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cma_pkg::SAMPLE_WIDTH-1:0] out_value,
  output logic                               out_last_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cma_pkg::WIN_W-1:0]          cfg_window_length
);

  import cma_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] store_mem [STORE_DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rd_a_r;
  logic signed [SAMPLE_WIDTH-1:0] rd_b_r;
  addr_t                          rd_a_addr;
  addr_t                          rd_b_addr;
  logic                           mem_we;

  cma_state_t state_r, state_nxt;

  win_t        cfg_win_r;
  win_t        win_r;
  addr_t       wr_pos_r;
  addr_t       cur_r;
  win_t        seen_r;
  win_t        c_r;
  logic signed [SUM_W-1:0]        tsum_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic        last_r;
  logic [SPAN_W-1:0] d_r;
  logic signed [SAMPLE_WIDTH-1:0] res_r;
  logic        res_last_r;
  logic [DIV_W-1:0]  quo_r;
  logic [WIN_W-1:0]  rem_r;
  logic        neg_r;
  logic [CNT_W-1:0]  cnt_r;

  logic        out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_value_r;
  logic        out_last_r;

  logic        in_acc;
  logic        out_free;
  logic        out_load;
  win_t        win_use;
  logic [SPAN_W-1:0] span_use;
  logic [SPAN_W-1:0] span;
  win_t        two_span;
  logic        c_ge_span;
  logic        c_ge_2span;
  logic [SPAN_W-1:0] k_val;
  logic signed [SAMPLE_WIDTH-1:0] sub_val;
  logic signed [SUM_W-1:0] tsum_new;
  logic signed [SUM_W-1:0] wsum;
  logic [SUM_W-1:0]  wmag;
  logic [DIV_W-1:0]  quo_v;
  logic [WIN_W-1:0]  rem_v;
  logic [WIN_W:0]    trial;
  logic [SAMPLE_WIDTH-1:0] q_mag;
  logic signed [SAMPLE_WIDTH-1:0] q_val;
  logic signed [SAMPLE_WIDTH-1:0] out_src;
  logic        out_src_last;

  assign win_use   = (seen_r == '0) ? win_clamp(cfg_win_r) : win_r;
  assign span_use  = win_use[WIN_W-1:1];
  assign span      = win_r[WIN_W-1:1];
  assign two_span  = {span, 1'b0};
  assign c_ge_span  = c_r >= win_t'(span);
  assign c_ge_2span = c_r >= two_span;
  assign k_val      = c_ge_span ? span : c_r[SPAN_W-1:0];

  assign sub_val  = (c_r >= win_r) ? rd_a_r : '0;
  assign tsum_new = tsum_r + SUM_W'(x_r) - SUM_W'(sub_val);
  assign wsum     = win_r[0] ? tsum_new : tsum_r;
  assign wmag     = wsum[SUM_W-1] ? SUM_W'(-wsum) : SUM_W'(wsum);

  always_comb begin
    rem_v = rem_r;
    quo_v = quo_r;
    trial = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_v, quo_v[DIV_W-1]};
      quo_v = {quo_v[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, win_r}) begin
        trial    = trial - {1'b0, win_r};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[WIN_W-1:0];
    end
  end

  assign q_mag = quo_v[SAMPLE_WIDTH-1:0];
  assign q_val = neg_r ? -$signed(q_mag) : $signed(q_mag);

  always_comb begin
    rd_a_addr = slot_back(wr_pos_r, win_use);
    if (state_r inside {ST_FL_RD, ST_FL_EM}) begin
      rd_b_addr = slot_back(cur_r, win_t'(d_r));
    end else begin
      rd_b_addr = slot_back(wr_pos_r, win_t'(span_use));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wr_pos_r] <= in_sample;
    end
    rd_a_r <= store_mem[rd_a_addr];
    rd_b_r <= store_mem[rd_b_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (last_r) begin
          if (c_ge_2span) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_FL_RD;
          end
        end else if (!c_ge_span) begin
          state_nxt = ST_IDLE;
        end else if (c_ge_2span) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (last_r && span != '0) begin
            state_nxt = ST_FL_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FL_RD: begin
        state_nxt = ST_FL_EM;
      end
      ST_FL_EM: begin
        if (out_free) begin
          if (d_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    out_load     = 1'b0;
    out_src      = res_r;
    out_src_last = res_last_r;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = 1'b1;
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      ST_FL_EM: begin
        out_load     = out_free;
        out_src      = rd_b_r;
        out_src_last = (d_r == '0);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign in_acc   = in_valid && !in_stall;
  assign mem_we   = in_acc;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_win_r   <= win_t'(1);
      win_r       <= win_t'(1);
      wr_pos_r    <= '0;
      seen_r      <= '0;
      tsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_win_r <= cfg_window_length;
      end
      if (in_acc) begin
        win_r    <= win_use;
        wr_pos_r <= (wr_pos_r == addr_t'(STORE_DEPTH - 1)) ? '0 : wr_pos_r + addr_t'(1);
        if (in_last_in) begin
          seen_r <= '0;
        end else if ({1'b0, seen_r} < {1'b0, win_use} + (WIN_W+1)'(1)) begin
          seen_r <= seen_r + win_t'(1);
        end
      end
      if (state_r == ST_CALC) begin
        tsum_r <= last_r ? '0 : tsum_new;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r    <= in_sample;
      last_r <= in_last_in;
      cur_r  <= wr_pos_r;
      c_r    <= seen_r;
    end
    case (state_r)
      ST_CALC: begin
        quo_r      <= DIV_W'(wmag);
        rem_r      <= '0;
        neg_r      <= wsum[SUM_W-1];
        cnt_r      <= '0;
        res_r      <= rd_b_r;
        res_last_r <= last_r && (span == '0);
        if (last_r) begin
          d_r <= k_val;
        end
      end
      ST_DIV: begin
        quo_r <= quo_v;
        rem_r <= rem_v;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          res_r <= q_val;
        end
      end
      ST_EMIT: begin
        if (span != '0) begin
          d_r <= span - SPAN_W'(1);
        end
      end
      ST_FL_EM: begin
        if (out_free && d_r != '0) begin
          d_r <= d_r - SPAN_W'(1);
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
    if (out_load) begin
      out_value_r <= out_src;
      out_last_r  <= out_src_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_last_out = out_last_r;

endmodule

`default_nettype wire
